FILE: rtl/svlr_pkg.sv
// Package for the sample voice linear resampler.
// Holds beat types, configuration types, register and mode codes, and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package svlr_pkg;

    localparam int SAMPLE_DEPTH  = 4096;
    localparam int ADDR_W        = $clog2(SAMPLE_DEPTH);
    localparam int FRACTION_BITS = 16;
    localparam int POS_BITS      = 29;
    localparam int IDX_W         = POS_BITS - FRACTION_BITS;
    localparam int COUNT_W       = 13;
    localparam int PITCH_W       = 24;
    localparam int GAIN_W        = 16;
    localparam int GAIN_BITS     = 12;
    localparam int SAMPLE_W      = 16;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 32;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_SAMPLE_COUNT  = 3'd0;
    localparam logic [2:0] REG_SAMPLE_FORMAT = 3'd1;
    localparam logic [2:0] REG_PITCH_STEP    = 3'd2;
    localparam logic [2:0] REG_LEFT_GAIN     = 3'd3;
    localparam logic [2:0] REG_RIGHT_GAIN    = 3'd4;
    localparam logic [2:0] REG_LOOP_ENABLE   = 3'd5;

    // Input beat modes.
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_PRODUCE = 2'd1;
    localparam logic [1:0] MODE_REWIND  = 2'd2;

    localparam logic FORMAT_EIGHT_BIT = 1'b0;

    typedef struct packed {
        logic [1:0]                 mode;
        logic [11:0]                load_address;
        logic signed [SAMPLE_W-1:0] load_value;
        logic signed [15:0]         mix_left;
        logic signed [15:0]         mix_right;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic               done_res;
    } out_beat_t;

    typedef struct packed {
        logic [COUNT_W-1:0] sample_count;
        logic               sample_format;
        logic [PITCH_W-1:0] pitch_step;
        logic [GAIN_W-1:0]  left_gain;
        logic [GAIN_W-1:0]  right_gain;
        logic               loop_enable;
    } cfg_t;

    // In eight-bit format only the low byte of a stored entry counts.
    function automatic logic signed [SAMPLE_W-1:0] to_sample(
        input logic [SAMPLE_W-1:0] raw,
        input logic                fmt
    );
        logic signed [SAMPLE_W-1:0] res;
        if (fmt == FORMAT_EIGHT_BIT)
        begin
            res = {{(SAMPLE_W-8){raw[7]}}, raw[7:0]};
        end
        else
        begin
            res = raw;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] res;
        if (v > 24'sd32767)
        begin
            res = 16'sh7fff;
        end
        else if (v < -24'sd32768)
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/svlr_cfg_regs.sv
// Configuration register file of the sample voice linear resampler.
// APB-style write and read access; depends on svlr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svlr_cfg_regs
    import svlr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         reg_index,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_count  <= COUNT_W'(4096);
            cfg_reg.sample_format <= 1'b1;
            cfg_reg.pitch_step    <= PITCH_W'(65536);
            cfg_reg.left_gain     <= GAIN_W'(4096);
            cfg_reg.right_gain    <= GAIN_W'(4096);
            cfg_reg.loop_enable   <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_SAMPLE_COUNT:  cfg_reg.sample_count  <= pwdata[COUNT_W-1:0];
                REG_SAMPLE_FORMAT: cfg_reg.sample_format <= pwdata[0];
                REG_PITCH_STEP:    cfg_reg.pitch_step    <= pwdata[PITCH_W-1:0];
                REG_LEFT_GAIN:     cfg_reg.left_gain     <= pwdata[GAIN_W-1:0];
                REG_RIGHT_GAIN:    cfg_reg.right_gain    <= pwdata[GAIN_W-1:0];
                REG_LOOP_ENABLE:   cfg_reg.loop_enable   <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_SAMPLE_COUNT:  prdata = PDATA_W'(cfg_reg.sample_count);
            REG_SAMPLE_FORMAT: prdata = PDATA_W'(cfg_reg.sample_format);
            REG_PITCH_STEP:    prdata = PDATA_W'(cfg_reg.pitch_step);
            REG_LEFT_GAIN:     prdata = PDATA_W'(cfg_reg.left_gain);
            REG_RIGHT_GAIN:    prdata = PDATA_W'(cfg_reg.right_gain);
            REG_LOOP_ENABLE:   prdata = PDATA_W'(cfg_reg.loop_enable);
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/svlr_sample_mem.sv
// Single-port sample store with a registered read port.
// One access per cycle, read or write; depends on svlr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svlr_sample_mem
    import svlr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [ADDR_W-1:0]   addr,
    input  wire logic [SAMPLE_W-1:0] wdata,
    output logic [SAMPLE_W-1:0]      rdata
);

    logic [SAMPLE_W-1:0] mem [SAMPLE_DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: rtl/svlr_mix_unit.sv
// Four-stage interpolate, gain and saturate pipeline.
// The caller must hold gains and mix values stable while it runs; the unit does not enforce this; depends on svlr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svlr_mix_unit
    import svlr_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [SAMPLE_W-1:0] a,
    input  wire logic signed [SAMPLE_W-1:0] b,
    input  wire logic [FRACTION_BITS-1:0]   frac,
    input  wire logic                       eight_bit,
    input  wire logic [GAIN_W-1:0]          gain_left,
    input  wire logic [GAIN_W-1:0]          gain_right,
    input  wire logic signed [15:0]         mix_left,
    input  wire logic signed [15:0]         mix_right,
    output logic                            res_valid,
    output logic signed [15:0]              res_left,
    output logic signed [15:0]              res_right
);

    localparam int PROD_W = SAMPLE_W + 1 + FRACTION_BITS + 1;
    localparam int V_W    = SAMPLE_W + 2;
    localparam int GP_W   = V_W + GAIN_W + 1;

    logic [3:0]                 vld_reg;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]   prod_s1_reg;
    logic signed [SAMPLE_W-1:0] a_s1_reg;
    logic signed [V_W-1:0]      interp;
    logic signed [V_W-1:0]      v_s2_reg;
    logic signed [GP_W-1:0]     pl_s3_reg;
    logic signed [GP_W-1:0]     pr_s3_reg;
    logic signed [23:0]         sum_left;
    logic signed [23:0]         sum_right;
    logic signed [15:0]         res_left_reg;
    logic signed [15:0]         res_right_reg;

    assign diff   = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
    // Arithmetic shift is the floor of the division.
    assign interp = {{2{a_s1_reg[SAMPLE_W-1]}}, a_s1_reg}
                    + V_W'(prod_s1_reg >>> FRACTION_BITS);
    assign sum_left  = 24'(pl_s3_reg >>> GAIN_BITS) + 24'(mix_left);
    assign sum_right = 24'(pr_s3_reg >>> GAIN_BITS) + 24'(mix_right);

    assign res_valid = vld_reg[3];
    assign res_left  = res_left_reg;
    assign res_right = res_right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], start};
        end
    end

    // Each stage loads only as its beat passes, so the result holds until the next beat reaches the last stage.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_s1_reg <= diff * $signed({1'b0, frac});
            a_s1_reg    <= a;
        end
        if (vld_reg[0])
        begin
            v_s2_reg <= eight_bit ? (interp <<< 1) : interp;
        end
        if (vld_reg[1])
        begin
            pl_s3_reg <= v_s2_reg * $signed({1'b0, gain_left});
            pr_s3_reg <= v_s2_reg * $signed({1'b0, gain_right});
        end
        if (vld_reg[2])
        begin
            res_left_reg  <= sat16(sum_left);
            res_right_reg <= sat16(sum_right);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sample_voice_linear_resampler.sv
// Top level of the sample voice linear resampler: sequencer, play position and output register.
// Instantiates svlr_cfg_regs, svlr_sample_mem and svlr_mix_unit; depends on svlr_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Handshake                Payload
//  ------    ----------------------   -------------------------------------------
//  input     in_valid / in_ready      in_beat  (in_beat_t: mode, load, mix values)
//  output    out_valid / out_ready    out_beat (out_beat_t: left, right, done_res)
//  config    psel/penable/pwrite      paddr, pwdata, prdata; pready tied high
//
//  A load, rewind or unused-mode beat is taken and frees the input at once.
//  A produce beat passes through two reads of the single-port sample store and the
//  four-stage mix pipeline before its result beat is offered; a produce beat for a
//  voice past its end skips the reads and the pipeline.
//  Reset clears the sequencer, the play position, the output valid and the registers to
//  their documented values; the sample store is not cleared and holds garbage until loaded.
//  A stalled output beat sits in the output register; the next input beat is accepted
//  meanwhile, and a produce beat waits in its last state until the output register frees.

module sample_voice_linear_resampler
    import svlr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire in_beat_t           in_beat,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output out_beat_t               out_beat,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    // One-hot sequencer states.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ADDR   = 6'b000010,
        S_RDB    = 6'b000100,
        S_INTERP = 6'b001000,
        S_MATH   = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    cfg_t cfg;

    logic [POS_BITS-1:0]      pos_reg, pos_next;
    logic [ADDR_W-1:0]        ib_reg, ib_next;
    logic [FRACTION_BITS-1:0] frac_reg, frac_next;
    logic                     done_reg, done_next;
    logic signed [15:0]       mix_l_reg, mix_r_reg;
    logic signed [SAMPLE_W-1:0] a_reg;
    logic                     out_valid_reg, out_valid_next;
    out_beat_t                out_beat_reg, out_beat_next;

    logic                     accept;
    logic                     load_in_range;
    logic [COUNT_W-1:0]       count_eff;
    logic [COUNT_W-1:0]       last_idx;
    logic [IDX_W-1:0]         ia_full;
    logic [POS_BITS:0]        pos_sum;
    logic [IDX_W:0]           ib_full;
    logic [COUNT_W-1:0]       ia_clamp;
    logic [COUNT_W:0]         ib_clamp;
    logic [POS_BITS-1:0]      pos_sat;
    logic                     past_end;
    logic                     out_free;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_addr;
    logic [SAMPLE_W-1:0]      mem_rdata;
    logic signed [SAMPLE_W-1:0] sample_rd;

    logic                     mix_start;
    logic                     mix_valid;
    logic signed [15:0]       mix_res_l, mix_res_r;

    svlr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .reg_index (paddr[4:2]),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .cfg       (cfg)
    );

    assign pready = 1'b1;

    svlr_sample_mem u_sample_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (in_beat.load_value),
        .rdata (mem_rdata)
    );

    svlr_mix_unit u_mix_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mix_start),
        .a          (a_reg),
        .b          (sample_rd),
        .frac       (frac_reg),
        .eight_bit  (cfg.sample_format == FORMAT_EIGHT_BIT),
        .gain_left  (cfg.left_gain),
        .gain_right (cfg.right_gain),
        .mix_left   (mix_l_reg),
        .mix_right  (mix_r_reg),
        .res_valid  (mix_valid),
        .res_left   (mix_res_l),
        .res_right  (mix_res_r)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign load_in_range = (32'(in_beat.load_address) < SAMPLE_DEPTH);
    assign sample_rd     = to_sample(mem_rdata, cfg.sample_format);

    // A zero count acts as one, and a count beyond the store acts as the store depth.
    always_comb
    begin
        if (cfg.sample_count == '0)
        begin
            count_eff = COUNT_W'(1);
        end
        else if (32'(cfg.sample_count) > SAMPLE_DEPTH)
        begin
            count_eff = COUNT_W'(SAMPLE_DEPTH);
        end
        else
        begin
            count_eff = cfg.sample_count;
        end
    end

    assign last_idx = count_eff - COUNT_W'(1);
    assign ia_full  = pos_reg[POS_BITS-1:FRACTION_BITS];
    assign pos_sum  = {1'b0, pos_reg} + (POS_BITS+1)'(cfg.pitch_step);
    assign ib_full  = pos_sum[POS_BITS:FRACTION_BITS];
    assign ia_clamp = (ia_full > last_idx) ? last_idx : ia_full;
    assign ib_clamp = (ib_full > {1'b0, last_idx}) ? {1'b0, last_idx} : ib_full;
    assign pos_sat  = pos_sum[POS_BITS] ? '1 : pos_sum[POS_BITS-1:0];
    assign past_end = !cfg.loop_enable && (ia_full >= count_eff);

    // The store has one port: a load writes only while the sequencer is idle, and the two
    // reads of a produce beat happen while no beat can be accepted, so they never collide.
    always_comb
    begin
        mem_we   = 1'b0;
        mem_addr = ADDR_W'(in_beat.load_address);
        case (state_reg)
            S_IDLE:
            begin
                mem_we = accept && (in_beat.mode == MODE_LOAD) && load_in_range;
            end
            S_ADDR:  mem_addr = ADDR_W'(ia_clamp);
            S_RDB:   mem_addr = ib_reg;
            default: ;
        endcase
    end

    assign mix_start = (state_reg == S_INTERP);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        ib_next        = ib_reg;
        frac_next      = frac_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_beat_next  = out_beat_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_beat.mode == MODE_PRODUCE)
                    begin
                        state_next = S_ADDR;
                    end
                    else if (in_beat.mode == MODE_REWIND)
                    begin
                        pos_next = '0;
                    end
                end
            end
            S_ADDR:
            begin
                // The first read is issued here; the position advances unless past the end.
                ib_next   = ADDR_W'(ib_clamp);
                frac_next = pos_reg[FRACTION_BITS-1:0];
                done_next = past_end;
                if (past_end)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    pos_next   = pos_sat;
                    state_next = S_RDB;
                end
            end
            S_RDB:    state_next = S_INTERP;
            S_INTERP: state_next = S_MATH;
            S_MATH:
            begin
                if (mix_valid)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (done_reg)
                    begin
                        out_beat_next = '{out_left: mix_l_reg, out_right: mix_r_reg,
                                          done_res: 1'b1};
                    end
                    else
                    begin
                        out_beat_next = '{out_left: mix_res_l, out_right: mix_res_r,
                                          done_res: 1'b0};
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ib_reg       <= ib_next;
        frac_reg     <= frac_next;
        out_beat_reg <= out_beat_next;
        if (accept)
        begin
            mix_l_reg <= in_beat.mix_left;
            mix_r_reg <= in_beat.mix_right;
        end
        // The first sample arrives from the store while the second read is issued.
        if (state_reg == S_RDB)
        begin
            a_reg <= sample_rd;
        end
    end

    // The mix pipeline only ever returns a result that the sequencer is waiting for.
    assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid |-> (state_reg == S_MATH))
        else $error("mix result outside the wait state");

    // The store is written only while the sequencer is idle, never during a produce beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_IDLE))
        else $error("sample store written during a produce beat");

    // A voice past its end leaves the play position where it was.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ADDR) && past_end) |=> $stable(pos_reg))
        else $error("position moved past the end");

    // A finished produce beat always leaves a result waiting in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && out_free) |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("produce beat finished without a result");

endmodule

`default_nettype wire
